[design/mklq_pkg.sv]
// ----------------------------------------------------------------------------
// mklq_pkg
// Types and constants shared by the keypad lockout qualifier.
// ----------------------------------------------------------------------------
package mklq_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_REPEAT_GAP = 2'd0,
    CFG_OK_GAP     = 2'd1,
    CFG_BACK_START = 2'd2
  } cfg_reg_e;

  localparam logic [15:0] REPEAT_GAP_RESET = 16'd150;
  localparam logic [15:0] OK_GAP_RESET     = 16'd100;
  localparam logic [31:0] BACK_START_RESET = 32'd0;

  // back hold time preset on an accepted press, and step per held poll
  localparam logic [15:0] BACK_ACCEPT_HOLD = 16'd200;
  localparam logic [15:0] BACK_HOLD_STEP   = 16'd100;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        up_level;
    logic        down_level;
    logic        ok_level;
    logic        back_level;
  } in_t;

  typedef struct packed {
    logic signed [15:0] menu_position;
    logic               ok_event;
    logic               back_event;
    logic [31:0]        back_hold_ms;
  } out_t;

endpackage

[design/menu_keypad_lockout_qualifier_core.sv]
// ----------------------------------------------------------------------------
// menu_keypad_lockout_qualifier_core
// Four-key menu keypad with a shared repeat lockout, menu position counter,
// ok/back event pulses and back hold time.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_ready     in_data  : one poll (time, four key levels)
//  out      out_valid / out_ready   out_data : position, events, hold time
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data : register write
//
//  One poll per cycle while the output is not stalled: input register, one
//  pass of qualify logic, result register; the result register loads as the
//  poll leaves the input register; each poll makes a single state update.
//  A stalled output holds the result; the input stage keeps taking items
//  until both registers are full. cfg_ready is always high.
//  Synchronous reset clears state and valid flags, gaps to 150 and 100 ms.
// ----------------------------------------------------------------------------
module menu_keypad_lockout_qualifier_core #(
  parameter int unsigned TIME_BITS     = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mklq_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mklq_pkg::out_t                        out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mklq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mklq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import mklq_pkg::*;

  logic [15:0]              repeat_gap;
  logic [15:0]              ok_gap;
  logic [31:0]              back_start;

  logic                     s1_valid;
  in_t                      s1;
  logic                     s1_advance;
  logic                     s1_fire;

  logic [TIME_BITS-1:0]     last_accept;
  logic [POSITION_BITS-1:0] position;
  logic [TIME_BITS-1:0]     hold;
  logic                     prev_back;

  logic [TIME_BITS-1:0]     last_accept_next;
  logic [POSITION_BITS-1:0] position_next;
  logic [TIME_BITS-1:0]     hold_next;
  out_t                     result;

  assign cfg_ready  = 1'b1;
  assign s1_advance = !out_valid || out_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_gap <= REPEAT_GAP_RESET;
      ok_gap     <= OK_GAP_RESET;
      back_start <= BACK_START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REPEAT_GAP: repeat_gap <= cfg_data[15:0];
        CFG_OK_GAP:     ok_gap     <= cfg_data[15:0];
        CFG_BACK_START: back_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_data;
    end
  end

  mklq_step #(
    .TIME_BITS     (TIME_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .item             (s1),
    .repeat_gap       (repeat_gap),
    .ok_gap           (ok_gap),
    .back_start       (back_start),
    .last_accept      (last_accept),
    .position         (position),
    .hold             (hold),
    .prev_back        (prev_back),
    .last_accept_next (last_accept_next),
    .position_next    (position_next),
    .hold_next        (hold_next),
    .result           (result)
  );

  // keypad state moves only when a poll leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_accept <= '0;
      position    <= '0;
      hold        <= '0;
      prev_back   <= 1'b0;
    end else if (s1_fire) begin
      last_accept <= last_accept_next;
      position    <= position_next;
      hold        <= hold_next;
      prev_back   <= s1.back_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(position) && $stable(last_accept) && $stable(hold))
    else $error("keypad state changed without a poll");

  a_event_time: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (result.ok_event || result.back_event)
      |=> last_accept == $past(TIME_BITS'(s1.now_ms)))
    else $error("accepted press did not move lockout time");

  a_event_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.ok_event && out_data.back_event))
    else $error("two key events in one poll");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> (position == $past(position))
             || (position == $past(position) + POSITION_BITS'(1))
             || (position == $past(position) - POSITION_BITS'(1)))
    else $error("menu position moved by more than one");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

[design/mklq_step.sv]
// ----------------------------------------------------------------------------
// mklq_step
// Qualifies one poll: shared lockout over up, down, ok, back in that order,
// menu position update and back hold-time tracking.
// ----------------------------------------------------------------------------
module mklq_step #(
  parameter int unsigned TIME_BITS     = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  mklq_pkg::in_t              item,
  input  logic [15:0]                repeat_gap,
  input  logic [15:0]                ok_gap,
  input  logic [31:0]                back_start,
  input  logic [TIME_BITS-1:0]       last_accept,
  input  logic [POSITION_BITS-1:0]   position,
  input  logic [TIME_BITS-1:0]       hold,
  input  logic                       prev_back,
  output logic [TIME_BITS-1:0]       last_accept_next,
  output logic [POSITION_BITS-1:0]   position_next,
  output logic [TIME_BITS-1:0]       hold_next,
  output mklq_pkg::out_t             result
);
  import mklq_pkg::*;

  localparam logic [TIME_BITS-1:0]     HOLD_PRESET = TIME_BITS'(BACK_ACCEPT_HOLD);
  localparam logic [TIME_BITS-1:0]     HOLD_STEP   = TIME_BITS'(BACK_HOLD_STEP);
  localparam logic [POSITION_BITS-1:0] POS_ONE     = POSITION_BITS'(1);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 rep_pass;
  logic                 ok_pass;
  logic                 up_acc;
  logic                 down_acc;
  logic                 ok_acc;
  logic                 back_acc;
  logic                 back_change;

  // An accepted key moves the lockout time to now, which locks out every
  // later key in the same poll, so at most one key is taken per poll.
  assign now_t       = TIME_BITS'(item.now_ms);
  assign diff        = now_t - last_accept;
  assign rep_pass    = diff > TIME_BITS'(repeat_gap);
  assign ok_pass     = diff > TIME_BITS'(ok_gap);
  assign up_acc      = !item.up_level && rep_pass;
  assign down_acc    = !item.down_level && rep_pass && !up_acc;
  assign ok_acc      = !item.ok_level && ok_pass && !up_acc && !down_acc;
  assign back_change = item.back_level != prev_back;
  assign back_acc    = back_change && !item.back_level && rep_pass
                       && !up_acc && !down_acc && !ok_acc;

  always_comb begin
    if (up_acc) begin
      position_next = position - POS_ONE;
    end else if (down_acc) begin
      position_next = position + POS_ONE;
    end else begin
      position_next = position;
    end

    if (up_acc || down_acc || ok_acc || back_acc) begin
      last_accept_next = now_t;
    end else begin
      last_accept_next = last_accept;
    end

    if (back_change) begin
      if (!item.back_level) begin
        hold_next = back_acc ? HOLD_PRESET : '0;
      end else begin
        hold_next = now_t - TIME_BITS'(back_start);
      end
    end else if (!item.back_level) begin
      hold_next = hold + HOLD_STEP;
    end else begin
      hold_next = hold;
    end
  end

  assign result.menu_position = 16'(position_next);
  assign result.ok_event      = ok_acc;
  assign result.back_event    = back_acc;
  assign result.back_hold_ms  = 32'(hold_next);

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad lockout qualifier: polls go in through a
// queued driver, a clocked monitor checks each result against a local model
// of the lockout, position counter, event pulses and back hold time.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import mklq_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  // index outside the register map, the write must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_t                       in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_t                      out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  menu_keypad_lockout_qualifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // keypad model state and register copies
  logic [15:0]        rep_gap    = REPEAT_GAP_RESET;
  logic [15:0]        ok_gap     = OK_GAP_RESET;
  logic [31:0]        back_start = BACK_START_RESET;
  logic [31:0]        last_press = '0;
  logic signed [15:0] position   = '0;
  logic [31:0]        hold_ms    = '0;
  logic               prev_back  = 1'b0;

  in_t  pending_polls[$];
  out_t expected_results[$];

  int unsigned polls_queued = 0;
  int unsigned polls_checked = 0;
  int unsigned settings_used = 1;
  int unsigned ok_seen = 0;
  int unsigned back_seen = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_pct = 6;

  function automatic bit lockout_clear(input logic [31:0] now, input logic [15:0] gap);
    logic [31:0] diff;
    diff = now - last_press;
    return diff > {16'd0, gap};
  endfunction

  function automatic out_t qualify_poll(input in_t p);
    out_t r;
    bit   back_free;
    r = '0;
    if (!p.up_level && lockout_clear(p.now_ms, rep_gap)) begin
      position   = position - 16'sd1;
      last_press = p.now_ms;
    end
    if (!p.down_level && lockout_clear(p.now_ms, rep_gap)) begin
      position   = position + 16'sd1;
      last_press = p.now_ms;
    end
    if (!p.ok_level && lockout_clear(p.now_ms, ok_gap)) begin
      r.ok_event = 1'b1;
      last_press = p.now_ms;
    end
    back_free = lockout_clear(p.now_ms, rep_gap);
    if (p.back_level != prev_back) begin
      if (!p.back_level) begin
        hold_ms = '0;
        if (back_free) begin
          r.back_event = 1'b1;
          last_press   = p.now_ms;
          hold_ms      = {16'd0, BACK_ACCEPT_HOLD};
        end
      end else begin
        hold_ms = p.now_ms - back_start;
      end
    end else if (!p.back_level) begin
      hold_ms = hold_ms + {16'd0, BACK_HOLD_STEP};
    end
    prev_back       = p.back_level;
    r.menu_position = position;
    r.back_hold_ms  = hold_ms;
    return r;
  endfunction

  // driver: holds each poll until taken, idles only between items
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(qualify_poll(in_data));
      if (!in_valid || in_ready) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= pending_polls.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // monitor: compares every result with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          report_field("menu_position", {16'd0, want.menu_position},
                       {16'd0, out_data.menu_position});
          report_field("ok_event", {31'd0, want.ok_event}, {31'd0, out_data.ok_event});
          report_field("back_event", {31'd0, want.back_event},
                       {31'd0, out_data.back_event});
          report_field("back_hold_ms", want.back_hold_ms, out_data.back_hold_ms);
          polls_checked++;
          ok_seen   += out_data.ok_event;
          back_seen += out_data.back_event;
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("menu_keypad_lockout_qualifier_core: mismatch");
      $finish;
    end
  end

  task automatic add_poll(input logic [31:0] now, input logic up, input logic down,
                          input logic ok, input logic back);
    in_t p;
    p.now_ms     = now;
    p.up_level   = up;
    p.down_level = down;
    p.ok_level   = ok;
    p.back_level = back;
    pending_polls.push_back(p);
    polls_queued++;
  endtask

  task automatic wait_drained();
    while (polls_checked != polls_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_REPEAT_GAP: rep_gap    = val[15:0];
      CFG_OK_GAP:     ok_gap     = val[15:0];
      CFG_BACK_START: back_start = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_gaps(input logic [15:0] rg, input logic [15:0] og,
                          input logic [31:0] bs);
    write_reg(CFG_REPEAT_GAP, {16'd0, rg});
    write_reg(CFG_OK_GAP, {16'd0, og});
    write_reg(CFG_BACK_START, bs);
    settings_used++;
  endtask

  // mostly realistic key activity with advancing time, some raw noise
  task automatic add_session(input int unsigned n);
    logic [31:0] t;
    logic        bk;
    int unsigned span;
    t    = $urandom;
    bk   = 1'($urandom_range(1));
    span = rep_gap + ok_gap + 40;
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        add_poll($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        t = t + $urandom_range(span);
        if ($urandom_range(3) == 0) bk = ~bk;
        add_poll(t, $urandom_range(9) > 2, $urandom_range(9) > 2, $urandom_range(9) > 2, bk);
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed polls at reset gaps
    add_poll(32'd0, 1, 1, 1, 1);        // back seen released after reset
    add_poll(32'd151, 0, 1, 1, 1);      // up just past the gap
    add_poll(32'd200, 1, 0, 1, 1);      // down locked out
    add_poll(32'd302, 0, 0, 1, 1);      // up taken, down locked in same poll
    add_poll(32'd403, 1, 1, 0, 1);      // ok past its own gap
    add_poll(32'd554, 1, 1, 1, 0);      // back press accepted
    add_poll(32'd600, 1, 1, 1, 0);
    add_poll(32'd700, 1, 1, 1, 0);
    add_poll(32'd800, 1, 1, 1, 1);      // release hold time
    add_poll(32'hFFFF_FFF0, 0, 0, 0, 0);
    add_poll(32'h0000_0090, 1, 0, 1, 0); // across the timestamp wrap
    add_poll(32'hFFFF_FFFF, 1, 1, 1, 1);
    add_poll(32'h0000_0126, 0, 1, 1, 1); // difference equal to gap: locked
    add_poll(32'h0000_0127, 0, 1, 1, 1);
    add_poll(32'h0000_0200, 1, 1, 0, 0);
    add_poll(32'h0000_0300, 1, 1, 1, 0);
    wait_drained();

    // zero gaps; down run, then an up run that takes the position below zero
    write_reg(CFG_UNMAPPED, $urandom);
    set_gaps(16'd0, 16'd0, $urandom);
    t = $urandom;
    repeat (150) begin
      t = t + 1;
      add_poll(t, 1, 0, 1, 1);
    end
    repeat (300) begin
      t = t + 1;
      add_poll(t, 0, 1, 1, 1);
    end
    add_session(300);
    wait_drained();

    set_gaps(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_session(300);
    wait_drained();

    // long stretch with no idling on either side
    idle_pct = 0;
    set_gaps(16'($urandom_range(400)), 16'($urandom_range(400)), $urandom);
    add_session(400);
    wait_drained();
    idle_pct = 6;

    repeat (4) begin
      set_gaps(16'($urandom_range(400)), 16'($urandom_range(400)), $urandom);
      add_session(80);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    $display("checked %0d polls over %0d register settings", polls_checked, settings_used);
    $display("ok events %0d, back events %0d, errors %0d", ok_seen, back_seen, errors);
    if (errors == 0) begin
      $display("menu_keypad_lockout_qualifier_core: match");
    end else begin
      $display("menu_keypad_lockout_qualifier_core: mismatch");
    end
    $finish;
  end

endmodule
